### hw/rtl/flash_program_erase_sequencer_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the flash program/erase sequencer
// Implication checks, clocked and disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef FLASH_PROGRAM_ERASE_SEQUENCER_CORE_ASSERT_SVH
`define FLASH_PROGRAM_ERASE_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define FPES_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fpes: same-cycle check failed");

// next-cycle implication
`define FPES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fpes: next-cycle check failed");

`endif

### hw/rtl/fpes_pkg.sv
// ----------------------------------------------------------------------------
// fpes_pkg
// Types and constants shared by the flash program/erase sequencer modules.
// ----------------------------------------------------------------------------
package fpes_pkg;

  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned DATA_W      = 16;
  localparam int unsigned POLL_W      = 23;
  localparam int unsigned PLIM_W      = 16;
  localparam int unsigned CODE_W      = 8;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_W       = 23;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned STEP_W      = 3;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_PROGRAM = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ERASE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_STATUS  = 2'd2;

  // result op codes
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_READ   = 3'd1;
  localparam logic [OP_W-1:0] OP_ENABLE = 3'd2;
  localparam logic [OP_W-1:0] OP_DONE   = 3'd3;
  localparam logic [OP_W-1:0] OP_ACCEPT = 3'd4;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRY_RUN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROG_POLL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ERASE_POLL = 2'd2;

  localparam logic [PLIM_W-1:0] PROG_POLL_RESET  = 16'h1000;
  localparam logic [POLL_W-1:0] ERASE_POLL_RESET = 23'h640000;

  // flash command words
  localparam logic [DATA_W-1:0] CMD_CLEAR_STATUS = 16'h5050;
  localparam logic [DATA_W-1:0] CMD_PROGRAM      = 16'h4040;
  localparam logic [DATA_W-1:0] CMD_ERASE        = 16'h2020;
  localparam logic [DATA_W-1:0] CMD_CONFIRM      = 16'hD0D0;
  localparam logic [DATA_W-1:0] CMD_READ_STATUS  = 16'h7070;
  localparam logic [DATA_W-1:0] CMD_READ_ARRAY   = 16'hFFFF;

  // status decode
  localparam int unsigned       STATUS_READY_BIT  = 7;
  localparam logic [CODE_W-1:0] PROG_STATUS_MASK  = 8'h98;
  localparam logic [CODE_W-1:0] ERASE_STATUS_MASK = 8'hE8;
  localparam logic [CODE_W-1:0] STATUS_GOOD       = 8'h80;
  localparam logic [CODE_W-1:0] CODE_BAD_ADDRESS  = 8'hFF;

  // erasable blocks
  localparam logic [ADDR_W-1:0] BLOCK_0 = 24'h000000;
  localparam logic [ADDR_W-1:0] BLOCK_1 = 24'h004000;
  localparam logic [ADDR_W-1:0] BLOCK_2 = 24'h006000;
  localparam logic [ADDR_W-1:0] BLOCK_3 = 24'h008000;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_BATCH,
    PH_PROG,
    PH_ERASE
  } phase_t;

  typedef enum logic [2:0] {
    JOB_DONE,
    JOB_ACCEPT,
    JOB_PROGRAM,
    JOB_ERASE,
    JOB_POLL,
    JOB_FINISH
  } job_kind_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic              first_word;
    logic              last_word;
    logic [DATA_W-1:0] flash_status;
  } in_item_t;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] bus_data;
    logic              program_enable;
    logic              success;
    logic [CODE_W-1:0] error_code;
    logic              last;
  } out_item_t;

  typedef struct packed {
    job_kind_t         kind;
    logic              enable_on;
    logic              ok;
    logic [CODE_W-1:0] code;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } job_t;

endpackage

### hw/rtl/flash_program_erase_sequencer_core.sv
// ----------------------------------------------------------------------------
// flash_program_erase_sequencer_core
// Command sequencer for a word-wide flash: program batches, block erase,
// status polling and completion, with a decoupled front and back.
// ----------------------------------------------------------------------------
//  port group | direction | handshake        | payload
//  in_        | input     | in_valid/stall   | in_item  (request or status reply)
//  out_       | output    | out_valid/stall  | out_item (bus operation or report)
//  cfg_       | input     | cfg_we           | cfg_index, cfg_wdata
//
//  The back sequencer emits one result per cycle while out_stall does not hold
//  the output register: a transaction causes 1 or 4 results for a status reply,
//  5 or 6 for a program word, 6 for an erase, 1 for a bad erase address or a
//  dry-run word and none for an ignored item, so throughput is set by that single result port.
//  A two-entry job queue lets the front accept new items while the back works.
//  rst_n is synchronous; it clears state, config, queue and output valid.
//  out_stall holds the output register; in_stall rises when the queue is full.
// ----------------------------------------------------------------------------
`include "flash_program_erase_sequencer_core_assert.svh"

module flash_program_erase_sequencer_core #(
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  fpes_pkg::in_item_t              in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output fpes_pkg::out_item_t             out_item,
  input  logic                            cfg_we,
  input  logic [fpes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpes_pkg::CFG_W-1:0]      cfg_wdata
);

  logic           in_accept;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;
  logic           seq_busy;
  fpes_pkg::job_t push_job;
  fpes_pkg::job_t head_job;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  fpes_front #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (in_accept),
    .item      (in_item),
    .push      (push),
    .job       (push_job)
  );

  fpes_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  fpes_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_job  (head_job),
    .q_empty   (q_empty),
    .pop       (pop),
    .busy      (seq_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // mid-sequence the job being expanded must still sit at the queue head
  `FPES_ASSERT_IMPL(a_busy_has_job, clk, rst_n, seq_busy, !q_empty)
  // a shown result that is not the last of its transaction leaves the sequencer mid-job
  `FPES_ASSERT_IMPL(a_nonlast_busy, clk, rst_n, out_valid && !out_item.last, seq_busy)
  // a report always closes its transaction
  `FPES_ASSERT_IMPL(a_done_last, clk, rst_n, out_valid && (out_item.op == fpes_pkg::OP_DONE), out_item.last)
  // after a last result is taken with nothing queued, the sequencer is idle
  `FPES_ASSERT_NEXT(a_idle_after_last, clk, rst_n, out_valid && !out_stall && out_item.last && q_empty, !seq_busy)

endmodule

### hw/rtl/fpes_front.sv
// ----------------------------------------------------------------------------
// fpes_front
// Holds config and sequencer state, classifies each accepted request and
// hands a job descriptor to the queue.
// ----------------------------------------------------------------------------
module fpes_front #(
  parameter int unsigned ADDRESS_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [fpes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpes_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                accept,
  input  fpes_pkg::in_item_t                  item,
  output logic                                push,
  output fpes_pkg::job_t                      job
);

  localparam int unsigned AW =
    (ADDRESS_BITS < fpes_pkg::ADDR_W) ? ADDRESS_BITS : fpes_pkg::ADDR_W;
  localparam int unsigned CW = fpes_pkg::POLL_W + 1;

  logic                          dry_run_r;
  logic [fpes_pkg::PLIM_W-1:0]   prog_limit_r;
  logic [fpes_pkg::POLL_W-1:0]   erase_limit_r;

  fpes_pkg::phase_t              phase_r, phase_nxt;
  logic [AW-1:0]                 word_addr_r, word_addr_nxt;
  logic [AW-1:0]                 batch_start_r, batch_start_nxt;
  logic [fpes_pkg::POLL_W-1:0]   poll_r, poll_nxt;
  logic                          ending_r, ending_nxt;

  logic [AW-1:0]                 addr_in;
  logic [fpes_pkg::ADDR_W-1:0]   addr_ext;
  logic [CW-1:0]                 cnt;
  logic                          ready;
  logic                          prog_timeout;
  logic                          erase_timeout;
  logic                          erase_addr_ok;
  logic [fpes_pkg::CODE_W-1:0]   st_low;
  logic                          prog_ok;
  logic [fpes_pkg::CODE_W-1:0]   erase_m;
  logic                          erase_ok;
  logic                          in_batch;
  logic                          dry;

  assign addr_in       = item.address[AW-1:0];
  assign addr_ext      = fpes_pkg::ADDR_W'(addr_in);
  assign cnt           = CW'(poll_r) + CW'(1);
  assign ready         = item.flash_status[fpes_pkg::STATUS_READY_BIT];
  assign prog_timeout  = cnt >= CW'(prog_limit_r);
  assign erase_timeout = cnt >= CW'(erase_limit_r);
  assign erase_addr_ok = (addr_ext == fpes_pkg::BLOCK_0) || (addr_ext == fpes_pkg::BLOCK_1) ||
                         (addr_ext == fpes_pkg::BLOCK_2) || (addr_ext == fpes_pkg::BLOCK_3);
  assign st_low        = item.flash_status[fpes_pkg::CODE_W-1:0];
  assign prog_ok       = (st_low & fpes_pkg::PROG_STATUS_MASK) == fpes_pkg::STATUS_GOOD;
  assign erase_m       = st_low & fpes_pkg::ERASE_STATUS_MASK;
  assign erase_ok      = erase_m == fpes_pkg::STATUS_GOOD;
  assign in_batch      = (phase_r == fpes_pkg::PH_IDLE) || (phase_r == fpes_pkg::PH_BATCH);
  assign dry           = (phase_r == fpes_pkg::PH_IDLE) && dry_run_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_run_r     <= 1'b0;
      prog_limit_r  <= fpes_pkg::PROG_POLL_RESET;
      erase_limit_r <= fpes_pkg::ERASE_POLL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fpes_pkg::CFG_DRY_RUN:    dry_run_r     <= cfg_wdata[0];
        fpes_pkg::CFG_PROG_POLL:  prog_limit_r  <= cfg_wdata[fpes_pkg::PLIM_W-1:0];
        fpes_pkg::CFG_ERASE_POLL: erase_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    phase_nxt       = phase_r;
    word_addr_nxt   = word_addr_r;
    batch_start_nxt = batch_start_r;
    poll_nxt        = poll_r;
    ending_nxt      = ending_r;
    if (accept) begin
      unique case (item.func)
        fpes_pkg::FUNC_PROGRAM: begin
          if (in_batch && !dry) begin
            if (phase_r == fpes_pkg::PH_IDLE || item.first_word) begin
              batch_start_nxt = addr_in;
            end
            word_addr_nxt = addr_in;
            phase_nxt     = fpes_pkg::PH_PROG;
            poll_nxt      = '0;
            ending_nxt    = item.last_word;
          end
        end
        fpes_pkg::FUNC_ERASE: begin
          if (phase_r == fpes_pkg::PH_IDLE && erase_addr_ok) begin
            word_addr_nxt = addr_in;
            phase_nxt     = fpes_pkg::PH_ERASE;
            poll_nxt      = '0;
          end
        end
        fpes_pkg::FUNC_STATUS: begin
          if (phase_r == fpes_pkg::PH_PROG) begin
            if (ready && !ending_r) begin
              phase_nxt = fpes_pkg::PH_BATCH;
              poll_nxt  = '0;
            end else if (ready || prog_timeout) begin
              phase_nxt  = fpes_pkg::PH_IDLE;
              poll_nxt   = '0;
              ending_nxt = 1'b0;
            end else begin
              poll_nxt = cnt[fpes_pkg::POLL_W-1:0];
            end
          end else if (phase_r == fpes_pkg::PH_ERASE) begin
            if (ready || erase_timeout) begin
              phase_nxt  = fpes_pkg::PH_IDLE;
              poll_nxt   = '0;
              ending_nxt = 1'b0;
            end else begin
              poll_nxt = cnt[fpes_pkg::POLL_W-1:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  // job descriptor
  always_comb begin
    push          = 1'b0;
    job           = '0;
    job.kind      = fpes_pkg::JOB_ACCEPT;
    if (accept) begin
      unique case (item.func)
        fpes_pkg::FUNC_PROGRAM: begin
          if (in_batch) begin
            push = 1'b1;
            if (dry) begin
              job.kind = item.last_word ? fpes_pkg::JOB_DONE : fpes_pkg::JOB_ACCEPT;
              job.ok   = 1'b1;
            end else begin
              job.kind      = fpes_pkg::JOB_PROGRAM;
              job.enable_on = (phase_r == fpes_pkg::PH_IDLE);
              job.addr      = addr_ext;
              job.data      = item.data;
            end
          end
        end
        fpes_pkg::FUNC_ERASE: begin
          if (phase_r == fpes_pkg::PH_IDLE) begin
            push = 1'b1;
            if (erase_addr_ok) begin
              job.kind = fpes_pkg::JOB_ERASE;
              job.addr = addr_ext;
            end else begin
              job.kind = fpes_pkg::JOB_DONE;
              job.code = fpes_pkg::CODE_BAD_ADDRESS;
            end
          end
        end
        fpes_pkg::FUNC_STATUS: begin
          if (phase_r == fpes_pkg::PH_PROG) begin
            push = 1'b1;
            if (ready && ending_r) begin
              job.kind = fpes_pkg::JOB_FINISH;
              job.addr = fpes_pkg::ADDR_W'(batch_start_r);
              job.ok   = prog_ok;
              job.code = prog_ok ? '0 : st_low;
            end else if (ready) begin
              job.kind = fpes_pkg::JOB_ACCEPT;
            end else if (prog_timeout) begin
              job.kind = fpes_pkg::JOB_FINISH;
              job.addr = fpes_pkg::ADDR_W'(word_addr_r);
              job.code = st_low;
            end else begin
              job.kind = fpes_pkg::JOB_POLL;
              job.addr = fpes_pkg::ADDR_W'(word_addr_r);
            end
          end else if (phase_r == fpes_pkg::PH_ERASE) begin
            push     = 1'b1;
            job.addr = fpes_pkg::ADDR_W'(word_addr_r);
            if (ready || erase_timeout) begin
              job.kind = fpes_pkg::JOB_FINISH;
              job.ok   = erase_ok;
              job.code = erase_ok ? '0 : erase_m;
            end else begin
              job.kind = fpes_pkg::JOB_POLL;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= fpes_pkg::PH_IDLE;
      word_addr_r   <= '0;
      batch_start_r <= '0;
      poll_r        <= '0;
      ending_r      <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      word_addr_r   <= word_addr_nxt;
      batch_start_r <= batch_start_nxt;
      poll_r        <= poll_nxt;
      ending_r      <= ending_nxt;
    end
  end

endmodule

### hw/rtl/fpes_queue.sv
// ----------------------------------------------------------------------------
// fpes_queue
// Short FIFO of job descriptors between the front and the back sequencer.
// ----------------------------------------------------------------------------
module fpes_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fpes_pkg::job_t push_job,
  input  logic           pop,
  output fpes_pkg::job_t head_job,
  output logic           empty,
  output logic           full
);

  localparam int unsigned DEPTH = fpes_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  fpes_pkg::job_t   slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### hw/rtl/fpes_back.sv
// ----------------------------------------------------------------------------
// fpes_back
// Expands the job at the queue head into bus results, one per cycle while
// out_stall does not hold the output register, into the output register.
// ----------------------------------------------------------------------------
module fpes_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fpes_pkg::job_t        head_job,
  input  logic                  q_empty,
  output logic                  pop,
  output logic                  busy,
  output logic                  out_valid,
  input  logic                  out_stall,
  output fpes_pkg::out_item_t   out_item
);

  localparam int unsigned SW = fpes_pkg::STEP_W;

  // positions within a program or erase command sequence
  localparam logic [SW-1:0] SEQ_ENABLE  = 3'd0;
  localparam logic [SW-1:0] SEQ_CLEAR   = 3'd1;
  localparam logic [SW-1:0] SEQ_CMD     = 3'd2;
  localparam logic [SW-1:0] SEQ_DATA    = 3'd3;
  localparam logic [SW-1:0] SEQ_STATUS  = 3'd4;
  // positions within the completion sequence
  localparam logic [SW-1:0] FIN_RESET_A = 3'd0;
  localparam logic [SW-1:0] FIN_RESET_B = 3'd1;
  localparam logic [SW-1:0] FIN_DISABLE = 3'd2;

  logic [SW-1:0]        step_r, step_nxt;
  logic [SW-1:0]        eff;
  logic                 is_prog;
  logic                 adv;
  logic                 gen;
  logic                 out_valid_r, out_valid_nxt;
  fpes_pkg::out_item_t  out_item_r;
  fpes_pkg::out_item_t  res;

  assign adv     = !out_valid_r || !out_stall;
  assign gen     = adv && !q_empty;
  assign pop     = gen && res.last;
  assign busy    = (step_r != '0);
  assign is_prog = (head_job.kind == fpes_pkg::JOB_PROGRAM);
  // a word inside a batch skips the enable step
  assign eff     = (is_prog && !head_job.enable_on) ? step_r + SW'(1) : step_r;

  always_comb begin
    res = '0;
    unique case (head_job.kind)
      fpes_pkg::JOB_DONE: begin
        res.op         = fpes_pkg::OP_DONE;
        res.success    = head_job.ok;
        res.error_code = head_job.code;
        res.last       = 1'b1;
      end
      fpes_pkg::JOB_ACCEPT: begin
        res.op   = fpes_pkg::OP_ACCEPT;
        res.last = 1'b1;
      end
      fpes_pkg::JOB_PROGRAM, fpes_pkg::JOB_ERASE: begin
        res.op          = fpes_pkg::OP_WRITE;
        res.bus_address = head_job.addr;
        unique case (eff)
          SEQ_ENABLE: begin
            res.op             = fpes_pkg::OP_ENABLE;
            res.bus_address    = '0;
            res.program_enable = 1'b1;
          end
          SEQ_CLEAR:  res.bus_data = fpes_pkg::CMD_CLEAR_STATUS;
          SEQ_CMD:    res.bus_data = is_prog ? fpes_pkg::CMD_PROGRAM : fpes_pkg::CMD_ERASE;
          SEQ_DATA:   res.bus_data = is_prog ? head_job.data : fpes_pkg::CMD_CONFIRM;
          SEQ_STATUS: res.bus_data = fpes_pkg::CMD_READ_STATUS;
          default: begin
            res.op   = fpes_pkg::OP_READ;
            res.last = 1'b1;
          end
        endcase
      end
      fpes_pkg::JOB_POLL: begin
        res.op          = fpes_pkg::OP_READ;
        res.bus_address = head_job.addr;
        res.last        = 1'b1;
      end
      fpes_pkg::JOB_FINISH: begin
        unique case (step_r)
          FIN_RESET_A, FIN_RESET_B: begin
            res.op          = fpes_pkg::OP_WRITE;
            res.bus_address = head_job.addr;
            res.bus_data    = fpes_pkg::CMD_READ_ARRAY;
          end
          FIN_DISABLE: res.op = fpes_pkg::OP_ENABLE;
          default: begin
            res.op         = fpes_pkg::OP_DONE;
            res.success    = head_job.ok;
            res.error_code = head_job.code;
            res.last       = 1'b1;
          end
        endcase
      end
      default: res.last = 1'b1;
    endcase
  end

  always_comb begin
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    if (gen) begin
      out_valid_nxt = 1'b1;
      step_nxt      = res.last ? '0 : step_r + SW'(1);
    end else if (adv) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (gen) begin
      out_item_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
